FILE: hw/rtl/sbq_pkg.sv
// Shared constants for the stereo biquad filter unit: coefficient format
// and configuration register indexes. No dependencies.
package sbq_pkg;

  localparam int COEF_W    = 32;  // Q3.28 signed
  localparam int COEF_FRAC = 28;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 3'd5;

  localparam logic [COEF_W-1:0] COEF_B0_RESET = 32'h1000_0000;  // 1.0

endpackage

FILE: hw/rtl/sbq_in_if.sv
// Sample request channel: valid/ready plus channel tag and input sample.
// No dependencies.
interface sbq_in_if #(
  parameter int CH_W         = 1,
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic [CH_W-1:0]                channel_index;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, channel_index, sample_in, input ready);
  modport sink   (input valid, channel_index, sample_in, output ready);
endinterface

FILE: hw/rtl/sbq_out_if.sv
// Result channel: valid/ready plus channel tag and filtered sample.
// No dependencies.
interface sbq_out_if #(
  parameter int CH_W         = 1,
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic [CH_W-1:0]                channel_out;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, channel_out, sample_out, input ready);
  modport sink   (input valid, channel_out, sample_out, output ready);
endinterface

FILE: hw/rtl/stereo_biquad_filter_unit.sv
// Stereo biquad filter unit: direct form I second-order section per channel.
// Depends on sbq_pkg, sbq_in_if, sbq_out_if and sbq_hist_mem.
//
//   channel   dir  handshake            payload
//   samples   in   valid/ready          channel_index, sample_in
//   results   out  valid/ready          channel_out, sample_out
//   cfg       in   cfg_wr_en (no wait)  cfg_index, cfg_data
//
// Three stages: history read, five coefficient products, sum/round/saturate
// into the output register. Throughput is one request per cycle while results
// are taken, except that a filtered request for the channel whose previous
// request is still in the product stage waits until that one reaches the sum
// stage (its y1 is not known yet), so one channel cannot run back to back.
// A result leaving the sum stage is forwarded to a same-channel read.
// Reset clears the pipeline, loads the coefficient reset values and marks all
// history entries invalid (they read as zero); no clearing pass is needed.
// A stalled result holds the output register; stages behind it keep filling.
module stereo_biquad_filter_unit
  import sbq_pkg::*;
#(
  parameter int CHANNELS     = 2,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  sbq_in_if.sink               samples,
  sbq_out_if.source            results
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW     = SAMPLE_WIDTH;
  localparam int PROD_W = COEF_W + SW;
  localparam int ACC_W  = PROD_W + 3;           // five-term sum
  localparam int Q_W    = ACC_W - COEF_FRAC;
  localparam int HIST_W = 4 * SW;               // {x1, x2, y1, y2}

  localparam logic signed [Q_W-1:0] Q_MAX =
    {{(Q_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN =
    {{(Q_W - SW + 1){1'b1}}, {(SW - 1){1'b0}}};
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);

  // Configuration registers
  logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic                     bypass_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0       <= COEF_B0_RESET;
      coef_b1       <= '0;
      coef_b2       <= '0;
      coef_a1       <= '0;
      coef_a2       <= '0;
      bypass_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_B0:     coef_b0       <= cfg_data;
        REG_B1:     coef_b1       <= cfg_data;
        REG_B2:     coef_b2       <= cfg_data;
        REG_A1:     coef_a1       <= cfg_data;
        REG_A2:     coef_a2       <= cfg_data;
        REG_BYPASS: bypass_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline state
  logic                 s1_valid, s1_filt, s1_fwd;
  logic [CH_W-1:0]      s1_ch;
  logic signed [SW-1:0] s1_x;
  logic [HIST_W-1:0]    fwd_data;

  logic                     s2_valid, s2_filt;
  logic [CH_W-1:0]          s2_ch;
  logic signed [SW-1:0]     s2_x, s2_x1, s2_y1;
  logic signed [PROD_W-1:0] s2_pb0, s2_pb1, s2_pb2, s2_pa1, s2_pa2;

  logic                 out_valid;
  logic [CH_W-1:0]      out_ch;
  logic signed [SW-1:0] out_sample;

  // Stage advance
  logic s2_move, s1_move, in_filt, in_same_s1, in_same_s2, accept;

  assign s2_move = !out_valid || results.ready;
  assign s1_move = !s2_valid || s2_move;

  // Filtered requests only; bypass and channels beyond the count pass through
  assign in_filt = !bypass_enable &&
                   ({1'b0, samples.channel_index} < (CH_W + 1)'(CHANNELS));
  assign in_same_s1 = s1_valid && s1_filt && (s1_ch == samples.channel_index);
  assign in_same_s2 = s2_valid && s2_filt && (s2_ch == samples.channel_index);

  // Same channel in the product stage: wait. In the sum stage: forward, but
  // only if it writes back on this edge.
  assign samples.ready = (!s1_valid || s1_move) &&
                         !(in_filt && in_same_s1) &&
                         !(in_filt && in_same_s2 && !s2_move);
  assign accept = samples.valid && samples.ready;

  // History memory
  logic [HIST_W-1:0] rd_data, wr_data, hist;
  logic              wr_en;

  sbq_hist_mem #(
    .DEPTH (CHANNELS),
    .AW    (CH_W),
    .DW    (HIST_W)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && in_filt),
    .rd_addr (samples.channel_index),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s2_ch),
    .wr_data (wr_data)
  );

  // Stage 1: history arrives, products formed
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_filt  <= in_filt;
      s1_ch    <= samples.channel_index;
      s1_x     <= samples.sample_in;
      s1_fwd   <= in_same_s2 && s2_move;
      fwd_data <= wr_data;
    end
  end

  logic signed [SW-1:0]     h_x1, h_x2, h_y1, h_y2;
  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;

  assign hist = s1_fwd ? fwd_data : rd_data;
  assign h_x1 = hist[4*SW-1 -: SW];
  assign h_x2 = hist[3*SW-1 -: SW];
  assign h_y1 = hist[2*SW-1 -: SW];
  assign h_y2 = hist[SW-1 -: SW];

  assign p_b0 = coef_b0 * s1_x;
  assign p_b1 = coef_b1 * h_x1;
  assign p_b2 = coef_b2 * h_x2;
  assign p_a1 = coef_a1 * h_y1;
  assign p_a2 = coef_a2 * h_y2;

  // Stage 2: sum, round half up, saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_filt <= s1_filt;
      s2_ch   <= s1_ch;
      s2_x    <= s1_x;
      s2_x1   <= h_x1;
      s2_y1   <= h_y1;
      s2_pb0  <= p_b0;
      s2_pb1  <= p_b1;
      s2_pb2  <= p_b2;
      s2_pa1  <= p_a1;
      s2_pa2  <= p_a2;
    end
  end

  logic signed [ACC_W-1:0] acc, acc_rnd;
  logic signed [Q_W-1:0]   q;
  logic signed [SW-1:0]    y_sat;

  always_comb begin
    acc = ACC_W'(s2_pb0) + ACC_W'(s2_pb1) + ACC_W'(s2_pb2)
        - ACC_W'(s2_pa1) - ACC_W'(s2_pa2);
    acc_rnd = acc + $signed(ROUND_HALF);
    q = acc_rnd[ACC_W-1:COEF_FRAC];
    if (q > Q_MAX) begin
      y_sat = Q_MAX[SW-1:0];
    end else if (q < Q_MIN) begin
      y_sat = Q_MIN[SW-1:0];
    end else begin
      y_sat = q[SW-1:0];
    end
  end

  // History shifts on write back
  assign wr_data = {s2_x, s2_x1, y_sat, s2_y1};
  assign wr_en   = s2_move && s2_valid && s2_filt;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_move) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && s2_valid) begin
      out_ch     <= s2_ch;
      out_sample <= s2_filt ? y_sat : s2_x;
    end
  end

  assign results.valid       = out_valid;
  assign results.channel_out = out_ch;
  assign results.sample_out  = out_sample;

endmodule

FILE: hw/rtl/sbq_hist_mem.sv
// Per-channel history store: one entry per channel, registered read,
// read-before-write. Valid bits make never-written entries read as zero.
module sbq_hist_mem #(
  parameter int DEPTH = 2,
  parameter int AW    = 1,
  parameter int DW    = 96
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] entry_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= entry_valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule
